// ----- hdl/pke_pkg.sv -----
`timescale 1ns / 1ps

package pke_pkg;

    // fixed-point formats
    localparam int VALUE_W  = 48;
    localparam int ELEM_W   = 16;
    localparam int ACC_FRAC = 24;
    localparam int HALF_W   = 24;
    localparam int SUM_W    = 73;
    localparam int DEG_W    = 4;
    localparam int STEP_W   = 3;

    localparam logic [VALUE_W-1:0] VALUE_ONE = VALUE_W'(1) << ACC_FRAC;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // configuration register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_DEGREE = 2'd2;

    // result register operations
    localparam logic [2:0] RES_HOLD = 3'd0;
    localparam logic [2:0] RES_LIN  = 3'd1;
    localparam logic [2:0] RES_POLY = 3'd2;
    localparam logic [2:0] RES_ONE  = 3'd3;
    localparam logic [2:0] RES_MUL  = 3'd4;

    // partial product select
    localparam logic [1:0] MUL_LL = 2'd0;
    localparam logic [1:0] MUL_HL = 2'd1;
    localparam logic [1:0] MUL_LH = 2'd2;
    localparam logic [1:0] MUL_HH = 2'd3;

    // partial sum operations
    localparam logic [1:0] SUM_NONE   = 2'd0;
    localparam logic [1:0] SUM_LOAD   = 2'd1;
    localparam logic [1:0] SUM_ADD    = 2'd2;
    localparam logic [1:0] SUM_ADD_HI = 2'd3;

    typedef struct packed {
        logic       load_prod;
        logic       add_prod;
        logic       clear_acc;
        logic [2:0] res_op;
        logic       mag_load;
        logic       mul_load;
        logic [1:0] mul_sel;
        logic [1:0] sum_op;
        logic       out_load;
    } pke_cmd_t;

endpackage

// ----- hdl/pke_datapath.sv -----
`timescale 1ns / 1ps

module pke_datapath #(
    parameter int ELEM_FRAC_BITS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pke_pkg::pke_cmd_t                   cmd,
    input  logic signed [pke_pkg::ELEM_W-1:0]   elem_a,
    input  logic signed [pke_pkg::ELEM_W-1:0]   elem_b,
    input  logic signed [pke_pkg::VALUE_W-1:0]  cfg_offset,
    output logic signed [pke_pkg::VALUE_W-1:0]  kernel_value,
    output logic                                overflow
);

    localparam int VW    = pke_pkg::VALUE_W;
    localparam int HW    = pke_pkg::HALF_W;
    localparam int PW    = 2 * pke_pkg::ELEM_W;
    localparam int ShL   = (pke_pkg::ACC_FRAC >= 2 * ELEM_FRAC_BITS) ?
                           pke_pkg::ACC_FRAC - 2 * ELEM_FRAC_BITS : 0;
    localparam int ShR   = (pke_pkg::ACC_FRAC >= 2 * ELEM_FRAC_BITS) ?
                           0 : 2 * ELEM_FRAC_BITS - pke_pkg::ACC_FRAC;

    logic signed [VW-1:0]         prod_reg;
    logic signed [VW-1:0]         acc_reg;
    logic                         sat_reg;
    logic signed [VW-1:0]         base_reg;
    logic signed [VW-1:0]         res_reg;
    logic                         flag_reg;
    logic [VW-1:0]                mag_a_reg;
    logic [VW-1:0]                mag_b_reg;
    logic                         neg_reg;
    logic [VW-1:0]                mult_reg;
    logic [pke_pkg::SUM_W-1:0]    sum_reg;
    logic                         hh_ovf_reg;
    logic signed [VW-1:0]         out_value_reg;
    logic                         out_ovf_reg;

    logic signed [PW-1:0]         elem_prod;
    logic signed [VW-1:0]         prod_ext;
    logic signed [VW-1:0]         prod_scaled;
    logic [VW:0]                  acc_sum;
    logic [VW-1:0]                acc_sat;
    logic                         acc_ovf;
    logic [VW:0]                  base_sum;
    logic [VW-1:0]                base_sat;
    logic                         base_ovf;
    logic [HW-1:0]                op_a;
    logic [HW-1:0]                op_b;
    logic [VW-1:0]                lim;
    logic                         mul_ovf;
    logic [VW-1:0]                mag_clamped;
    logic [VW-1:0]                mul_value;

    // element product rescaled to the accumulator format
    always_comb begin
        elem_prod = elem_a * elem_b;
        prod_ext  = {{(VW-PW){elem_prod[PW-1]}}, elem_prod};
        if (ShR == 0) begin
            prod_scaled = prod_ext <<< ShL;
        end else begin
            prod_scaled = prod_ext >>> ShR;
        end
    end

    // saturating accumulate and offset add
    always_comb begin
        acc_sum  = {acc_reg[VW-1], acc_reg} + {prod_reg[VW-1], prod_reg};
        acc_ovf  = acc_sum[VW] ^ acc_sum[VW-1];
        acc_sat  = acc_ovf ? (acc_sum[VW] ? pke_pkg::VALUE_MIN : pke_pkg::VALUE_MAX)
                           : acc_sum[VW-1:0];
        base_sum = {acc_reg[VW-1], acc_reg} + {cfg_offset[VW-1], cfg_offset};
        base_ovf = base_sum[VW] ^ base_sum[VW-1];
        base_sat = base_ovf ? (base_sum[VW] ? pke_pkg::VALUE_MIN : pke_pkg::VALUE_MAX)
                            : base_sum[VW-1:0];
    end

    // operand halves for the shared 24x24 multiplier
    always_comb begin
        unique case (cmd.mul_sel)
            pke_pkg::MUL_LL: begin
                op_a = mag_a_reg[HW-1:0];
                op_b = mag_b_reg[HW-1:0];
            end
            pke_pkg::MUL_HL: begin
                op_a = mag_a_reg[VW-1:HW];
                op_b = mag_b_reg[HW-1:0];
            end
            pke_pkg::MUL_LH: begin
                op_a = mag_a_reg[HW-1:0];
                op_b = mag_b_reg[VW-1:HW];
            end
            default: begin
                op_a = mag_a_reg[VW-1:HW];
                op_b = mag_b_reg[VW-1:HW];
            end
        endcase
    end

    // clamp magnitude and restore sign
    always_comb begin
        lim         = neg_reg ? pke_pkg::VALUE_MIN : pke_pkg::VALUE_MAX;
        mul_ovf     = hh_ovf_reg || (sum_reg > pke_pkg::SUM_W'(lim));
        mag_clamped = mul_ovf ? lim : sum_reg[VW-1:0];
        mul_value   = neg_reg ? (~mag_clamped + 1'b1) : mag_clamped;
    end

    // accumulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end else if (cmd.clear_acc) begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end else if (cmd.add_prod) begin
            acc_reg <= acc_sat;
            sat_reg <= sat_reg | acc_ovf;
        end
    end

    // product stage
    always_ff @(posedge aclk) begin
        if (cmd.load_prod) begin
            prod_reg <= prod_scaled;
        end
    end

    // result and power base
    always_ff @(posedge aclk) begin
        unique case (cmd.res_op)
            pke_pkg::RES_LIN: begin
                res_reg  <= acc_reg;
                flag_reg <= sat_reg;
            end
            pke_pkg::RES_POLY: begin
                res_reg  <= base_sat;
                base_reg <= base_sat;
                flag_reg <= sat_reg | base_ovf;
            end
            pke_pkg::RES_ONE: begin
                res_reg  <= pke_pkg::VALUE_ONE;
                flag_reg <= sat_reg | base_ovf;
            end
            pke_pkg::RES_MUL: begin
                res_reg  <= mul_value;
                flag_reg <= flag_reg | mul_ovf;
            end
            default: begin
                res_reg <= res_reg;
            end
        endcase
    end

    // magnitudes for one power step
    always_ff @(posedge aclk) begin
        if (cmd.mag_load) begin
            mag_a_reg <= res_reg[VW-1] ? (~res_reg + 1'b1) : res_reg;
            mag_b_reg <= base_reg[VW-1] ? (~base_reg + 1'b1) : base_reg;
            neg_reg   <= res_reg[VW-1] ^ base_reg[VW-1];
        end
    end

    // partial product register
    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            mult_reg <= {{HW{1'b0}}, op_a} * {{HW{1'b0}}, op_b};
        end
    end

    // partial sum of the product shifted down by the fraction width
    always_ff @(posedge aclk) begin
        unique case (cmd.sum_op)
            pke_pkg::SUM_LOAD: begin
                sum_reg    <= pke_pkg::SUM_W'(mult_reg[VW-1:HW]);
                hh_ovf_reg <= 1'b0;
            end
            pke_pkg::SUM_ADD: begin
                sum_reg <= sum_reg + pke_pkg::SUM_W'(mult_reg);
            end
            pke_pkg::SUM_ADD_HI: begin
                sum_reg    <= sum_reg + pke_pkg::SUM_W'({mult_reg, {HW{1'b0}}});
                hh_ovf_reg <= |mult_reg[VW-1:HW-1];
            end
            default: begin
                sum_reg <= sum_reg;
            end
        endcase
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_value_reg <= res_reg;
            out_ovf_reg   <= flag_reg;
        end
    end

    assign kernel_value = out_value_reg;
    assign overflow     = out_ovf_reg;

endmodule

// ----- hdl/pke_ctrl.sv -----
`timescale 1ns / 1ps

module pke_ctrl #(
    parameter int MAX_DEGREE = 15
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_last_element,
    output logic                          s_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          cfg_mode,
    input  logic [pke_pkg::DEG_W-1:0]     cfg_degree,
    output pke_pkg::pke_cmd_t             cmd
);

    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ST_ADD_LAST = 3'd1;
    localparam logic [2:0] ST_FINAL    = 3'd2;
    localparam logic [2:0] ST_MUL      = 3'd3;
    localparam logic [2:0] ST_OUT      = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic                        prod_valid_reg, prod_valid_next;
    logic [pke_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [pke_pkg::DEG_W-1:0]   count_reg, count_next;
    logic                        m_valid_reg, m_valid_next;
    logic [pke_pkg::DEG_W-1:0]   deg_eff;
    logic                        accept;

    assign s_ready = (state_reg == ST_RUN);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // applied degree
    always_comb begin
        if (int'(cfg_degree) > MAX_DEGREE) begin
            deg_eff = MAX_DEGREE[pke_pkg::DEG_W-1:0];
        end else begin
            deg_eff = cfg_degree;
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        prod_valid_next = prod_valid_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        cmd             = '0;
        cmd.res_op      = pke_pkg::RES_HOLD;
        cmd.mul_sel     = pke_pkg::MUL_LL;
        cmd.sum_op      = pke_pkg::SUM_NONE;

        unique case (state_reg)
            ST_RUN: begin
                cmd.load_prod   = accept;
                cmd.add_prod    = prod_valid_reg;
                prod_valid_next = accept && !s_last_element;
                if (accept && s_last_element) begin
                    state_next = ST_ADD_LAST;
                end
            end
            ST_ADD_LAST: begin
                cmd.add_prod = 1'b1;
                state_next   = ST_FINAL;
            end
            ST_FINAL: begin
                cmd.clear_acc = 1'b1;
                step_next     = '0;
                if (!cfg_mode) begin
                    cmd.res_op = pke_pkg::RES_LIN;
                    state_next = ST_OUT;
                end else if (deg_eff == '0) begin
                    cmd.res_op = pke_pkg::RES_ONE;
                    state_next = ST_OUT;
                end else begin
                    cmd.res_op = pke_pkg::RES_POLY;
                    count_next = deg_eff - 1'b1;
                    state_next = (deg_eff == pke_pkg::DEG_W'(1)) ? ST_OUT : ST_MUL;
                end
            end
            ST_MUL: begin
                step_next = step_reg + 1'b1;
                // four partial products through one multiplier, summed one behind
                unique case (step_reg)
                    3'd0: cmd.mag_load = 1'b1;
                    3'd1: begin
                        cmd.mul_load = 1'b1;
                        cmd.mul_sel  = pke_pkg::MUL_LL;
                    end
                    3'd2: begin
                        cmd.mul_load = 1'b1;
                        cmd.mul_sel  = pke_pkg::MUL_HL;
                        cmd.sum_op   = pke_pkg::SUM_LOAD;
                    end
                    3'd3: begin
                        cmd.mul_load = 1'b1;
                        cmd.mul_sel  = pke_pkg::MUL_LH;
                        cmd.sum_op   = pke_pkg::SUM_ADD;
                    end
                    3'd4: begin
                        cmd.mul_load = 1'b1;
                        cmd.mul_sel  = pke_pkg::MUL_HH;
                        cmd.sum_op   = pke_pkg::SUM_ADD;
                    end
                    3'd5: cmd.sum_op = pke_pkg::SUM_ADD_HI;
                    default: begin
                        cmd.res_op = pke_pkg::RES_MUL;
                        step_next  = '0;
                        count_next = count_reg - 1'b1;
                        if (count_reg == pke_pkg::DEG_W'(1)) begin
                            state_next = ST_OUT;
                        end
                    end
                endcase
            end
            ST_OUT: begin
                cmd.out_load = !m_valid_reg || m_ready;
                if (cmd.out_load) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    // output valid
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            prod_valid_reg <= 1'b0;
            step_reg       <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            prod_valid_reg <= prod_valid_next;
            step_reg       <= step_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

endmodule

// ----- hdl/polynomial_kernel_engine_unit.sv -----
`timescale 1ns / 1ps

// Streaming dot product of signed Q4.12 element pairs into a saturating Q24.24
// accumulator, with an optional polynomial kernel (dot + offset)^degree. Pairs
// are taken one per cycle while a vector streams in. After the pair marked
// last, input stalls while the last product is added and the result formed,
// and in polynomial mode (degree limited to MAX_DEGREE) for every power step
// after the first; each runs its four 24x24 partial products through one
// shared multiplier, plus magnitude, sum and clamp steps. A new result cannot
// enter the output register while one waits there, and input stays closed.
// Registers sit at byte addresses 0 (mode), 8 (offset), 16 (degree), 64 bits.
module polynomial_kernel_engine_unit #(
    parameter int ELEM_FRAC_BITS = 12,
    parameter int MAX_DEGREE     = 15
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_elem_a,
    input  logic signed [15:0] s_elem_b,
    input  logic               s_last_element,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [47:0] m_kernel_value,
    output logic               m_overflow
);

    logic                               cfg_mode_reg;
    logic signed [pke_pkg::VALUE_W-1:0] cfg_offset_reg;
    logic [pke_pkg::DEG_W-1:0]          cfg_degree_reg;
    logic [1:0]                         reg_index;
    logic                               cfg_write;
    pke_pkg::pke_cmd_t                  cmd;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:3];
    assign cfg_write = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_mode_reg   <= 1'b0;
            cfg_offset_reg <= '0;
            cfg_degree_reg <= pke_pkg::DEG_W'(1);
        end else if (cfg_write) begin
            unique case (reg_index)
                pke_pkg::REG_MODE:   cfg_mode_reg   <= pwdata[0];
                pke_pkg::REG_OFFSET: cfg_offset_reg <= pwdata[pke_pkg::VALUE_W-1:0];
                pke_pkg::REG_DEGREE: cfg_degree_reg <= pwdata[pke_pkg::DEG_W-1:0];
                default:             cfg_mode_reg   <= cfg_mode_reg;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_index)
            pke_pkg::REG_MODE:   prdata = {63'b0, cfg_mode_reg};
            pke_pkg::REG_OFFSET: prdata = {{(64-pke_pkg::VALUE_W){cfg_offset_reg[47]}},
                                           cfg_offset_reg};
            pke_pkg::REG_DEGREE: prdata = {{(64-pke_pkg::DEG_W){1'b0}}, cfg_degree_reg};
            default:             prdata = '0;
        endcase
    end

    pke_ctrl #(
        .MAX_DEGREE(MAX_DEGREE)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_last_element (s_last_element),
        .s_ready        (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .cfg_mode       (cfg_mode_reg),
        .cfg_degree     (cfg_degree_reg),
        .cmd            (cmd)
    );

    pke_datapath #(
        .ELEM_FRAC_BITS(ELEM_FRAC_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .elem_a       (s_elem_a),
        .elem_b       (s_elem_b),
        .cfg_offset   (cfg_offset_reg),
        .kernel_value (m_kernel_value),
        .overflow     (m_overflow)
    );

endmodule

// ----- hdl/pke_checker.sv -----
`timescale 1ns / 1ps

module pke_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_last_element,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [47:0] m_kernel_value,
    input logic               m_overflow
);

    // a waiting result holds until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kernel_value) && $stable(m_overflow))
        else $error("result item changed or dropped while stalled");

    // input closes right after the last pair of a vector
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_element |=> !s_ready)
        else $error("input still open after last pair");

    // a new result appears only after the input was closed for its vector
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result item without a finished vector");

endmodule

bind polynomial_kernel_engine_unit pke_checker u_pke_checker (.*);
